// File: hw/rtl/dmsc_pkg.sv
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared constants, register codes and stage control type of the demosaic core.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsc_pkg;

  // Default build sizes
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // Configuration register file
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 12;
  localparam int CFG_DATA_BITS   = 12;
  localparam int CFG_INDEX_BITS  = 1;

  localparam logic [WIDTH_REG_BITS-1:0]  RESET_WIDTH  = 11'd390;
  localparam logic [HEIGHT_REG_BITS-1:0] RESET_HEIGHT = 12'd300;
  localparam int MIN_DIM = 2;

  // Input row counts on past the frame during the drain, so one bit more
  localparam int ROW_BITS     = HEIGHT_REG_BITS + 1;
  localparam int OUT_ROW_BITS = HEIGHT_REG_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // What the window stage must do with one item
  typedef struct packed {
    logic emit_edge;   // right-edge pixel from the window as held
    logic emit_body;   // pixel from the window after the shift
    logic row_odd;
    logic col_odd;
    logic top;
    logic bottom;
    logic first_col;
    logic last;
  } s1_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/dmsc_if.sv
// ----------------------------------------------------------------------------
// Demosaic stream interfaces
// Raw sample channel and RGB result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmsc_in_if #(
  parameter int PIXEL_BITS = dmsc_pkg::DEF_PIXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] raw_pixel;
  logic                  flush;

  modport source (output valid, output raw_pixel, output flush, input ready);
  modport sink   (input valid, input raw_pixel, input flush, output ready);
endinterface

interface dmsc_out_if #(
  parameter int PIXEL_BITS = dmsc_pkg::DEF_PIXEL_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] red;
  logic [PIXEL_BITS-1:0] green;
  logic [PIXEL_BITS-1:0] blue;
  logic                  last_pixel;

  modport source (output valid, output red, output green, output blue,
                  output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dmsc_line_mem.sv
// ----------------------------------------------------------------------------
// Demosaic line store
// Simple dual-port RAM holding both buffered lines side by side per column.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsc_line_mem #(
  parameter int DEPTH = dmsc_pkg::DEF_MAX_WIDTH,
  parameter int DW    = 2 * dmsc_pkg::DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bilinear_bayer_demosaic_core.sv
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic core
// GRBG raw stream in, one RGB pixel per raw sample out, mirrored borders.
// ----------------------------------------------------------------------------
// The core takes one raw sample per clock and gives one RGB pixel per sample
// when neither side stalls; a frame of W x H pixels is followed by W+1 flush
// items. Each item first reads its column of the line store (one RAM, both
// buffered lines side by side, read and write port) into a registered read
// stage, then enters the 3x3 window, where the colour means are formed and
// the column is written back; the result is registered into a two-entry
// output queue, and the input stays open only while that queue has room for
// every item already taken. Pixel (r,c) leaves after input (r+1,c+1), one line
// plus one pixel behind. Writing either size register restarts the frame; the
// line store is never cleared, since no result depends on an unwritten entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_bayer_demosaic_core #(
  parameter int MAX_WIDTH  = dmsc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = dmsc_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dmsc_in_if.sink                             in_px,
  dmsc_out_if.source                          out_px,
  input  logic                                cfg_we,
  input  logic [dmsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dmsc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  import dmsc_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WB > WIDTH_REG_BITS) ? WB : WIDTH_REG_BITS;
  localparam int SW  = PIXEL_BITS + 2;
  localparam int RW  = 3 * PIXEL_BITS + 1;

  // --------------------------------------------------------------------------
  // Size registers
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_BITS-1:0]  width_r, width_nxt;
  logic [HEIGHT_REG_BITS-1:0] height_r, height_nxt;
  logic                       cfg_restart;

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          width_nxt   = cfg_wdata[WIDTH_REG_BITS-1:0];
          cfg_restart = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          height_nxt  = cfg_wdata[HEIGHT_REG_BITS-1:0];
          cfg_restart = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Clamp sizes to what the line store and counters can hold
  logic [EW-1:0]              w_raw, w_eff, w_m1;
  logic [HEIGHT_REG_BITS-1:0] h_eff, h_m1;

  assign w_raw = EW'(width_r);
  assign w_eff = (w_raw < EW'(MIN_DIM))   ? EW'(MIN_DIM)   :
                 (w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw;
  assign w_m1  = w_eff - EW'(1);
  assign h_eff = (height_r < HEIGHT_REG_BITS'(MIN_DIM)) ? HEIGHT_REG_BITS'(MIN_DIM)
                                                        : height_r;
  assign h_m1  = h_eff - HEIGHT_REG_BITS'(1);

  // --------------------------------------------------------------------------
  // Position counters and item decode
  // --------------------------------------------------------------------------
  logic [AW-1:0]           in_col_r, in_col_nxt;
  logic [ROW_BITS-1:0]     in_row_r, in_row_nxt;
  logic [AW-1:0]           out_col_r, out_col_nxt;
  logic [OUT_ROW_BITS-1:0] out_row_r, out_row_nxt;

  logic                  accept, in_frame, take;
  logic                  emit_edge, emit_body;
  s1_ctrl_t              ctrl;
  logic [PIXEL_BITS-1:0] pix;

  assign accept    = in_px.valid && in_px.ready;
  assign in_frame  = in_row_r < {1'b0, h_eff};
  assign take      = accept && !(in_px.flush && in_frame);
  assign pix       = in_frame ? in_px.raw_pixel : '0;
  assign emit_edge = (in_col_r == '0) && (in_row_r >= ROW_BITS'(2));
  assign emit_body = (in_col_r != '0) && (in_row_r != '0);

  always_comb begin
    ctrl.emit_edge = emit_edge;
    ctrl.emit_body = emit_body;
    ctrl.row_odd   = out_row_r[0];
    ctrl.col_odd   = out_col_r[0];
    ctrl.top       = (out_row_r == '0);
    ctrl.bottom    = (out_row_r == h_m1);
    ctrl.first_col = (out_col_r == '0);
    ctrl.last      = (emit_edge || emit_body) && (out_row_r == h_m1) &&
                     (EW'(out_col_r) == w_m1);
  end

  // Advance input and output positions, restart on frame end or size write
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (emit_edge || emit_body) begin
        if (EW'(out_col_r) == w_m1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OUT_ROW_BITS'(1);
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end
      if (EW'(in_col_r) == w_m1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_BITS'(1);
      end else begin
        in_col_nxt = in_col_r + AW'(1);
      end
      if (ctrl.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: read at take, write back from the window stage
  // --------------------------------------------------------------------------
  logic                    s1_valid_r;
  s1_ctrl_t                s1_ctrl_r;
  logic [PIXEL_BITS-1:0]   s1_pix_r;
  logic [AW-1:0]           s1_addr_r;
  logic                    fwd_r;
  logic [2*PIXEL_BITS-1:0] fwd_data_r;
  logic [2*PIXEL_BITS-1:0] mem_rd, col_ab, wr_data;

  dmsc_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIXEL_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (mem_rd),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  // Upper line gets the old lower line, lower line gets the new sample
  assign col_ab  = fwd_r ? fwd_data_r : mem_rd;
  assign wr_data = {col_ab[PIXEL_BITS-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= take;
      // Forward the write-back when a restarted frame reads the same column
      fwd_r      <= take && s1_valid_r && (s1_addr_r == in_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctrl_r <= ctrl;
      s1_pix_r  <= pix;
      s1_addr_r <= in_col_r;
    end
    fwd_data_r <= wr_data;
  end

  // --------------------------------------------------------------------------
  // 3x3 window and colour means
  // --------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] win_r [3][3];
  logic [PIXEL_BITS-1:0] col_new [3];
  logic [PIXEL_BITS-1:0] vc [3][3];
  logic [PIXEL_BITS-1:0] vt [3][3];
  logic [PIXEL_BITS-1:0] v [3][3];

  assign col_new[0] = col_ab[2*PIXEL_BITS-1:PIXEL_BITS];
  assign col_new[1] = col_ab[PIXEL_BITS-1:0];
  assign col_new[2] = s1_pix_r;

  // Shift the window one column, drop it at frame end or restart
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= s1_ctrl_r.last ? '0 : win_r[i][1];
        win_r[i][1] <= s1_ctrl_r.last ? '0 : win_r[i][2];
        win_r[i][2] <= s1_ctrl_r.last ? '0 : col_new[i];
      end
    end
  end

  // Neighbourhood of the output pixel with column and row mirrors applied
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vc[i][1] = win_r[i][2];
      if (s1_ctrl_r.emit_edge) begin
        vc[i][0] = win_r[i][1];
        vc[i][2] = win_r[i][1];
      end else begin
        vc[i][0] = s1_ctrl_r.first_col ? col_new[i] : win_r[i][1];
        vc[i][2] = col_new[i];
      end
    end
    for (int j = 0; j < 3; j++) begin
      vt[0][j] = s1_ctrl_r.top ? vc[2][j] : vc[0][j];
      vt[1][j] = vc[1][j];
      vt[2][j] = vc[2][j];
    end
    for (int j = 0; j < 3; j++) begin
      v[0][j] = vt[0][j];
      v[1][j] = vt[1][j];
      v[2][j] = s1_ctrl_r.bottom ? vt[0][j] : vt[2][j];
    end
  end

  logic [SW-1:0]         sum_hor, sum_ver, sum_crs, sum_dia;
  logic [PIXEL_BITS-1:0] mean_hor, mean_ver, mean_crs, mean_dia, ctr;
  logic [PIXEL_BITS-1:0] red_c, green_c, blue_c;

  assign sum_hor  = SW'(v[1][0]) + SW'(v[1][2]);
  assign sum_ver  = SW'(v[0][1]) + SW'(v[2][1]);
  assign sum_crs  = sum_hor + sum_ver;
  assign sum_dia  = SW'(v[0][0]) + SW'(v[0][2]) + SW'(v[2][0]) + SW'(v[2][2]);
  assign mean_hor = sum_hor[PIXEL_BITS:1];
  assign mean_ver = sum_ver[PIXEL_BITS:1];
  assign mean_crs = sum_crs[PIXEL_BITS+1:2];
  assign mean_dia = sum_dia[PIXEL_BITS+1:2];
  assign ctr      = v[1][1];

  // Pick sampled and interpolated colours by Bayer phase
  always_comb begin
    case ({s1_ctrl_r.row_odd, s1_ctrl_r.col_odd})
      2'b00: begin
        green_c = ctr;      red_c = mean_hor;  blue_c = mean_ver;
      end
      2'b01: begin
        red_c = ctr;        green_c = mean_crs; blue_c = mean_dia;
      end
      2'b10: begin
        blue_c = ctr;       green_c = mean_crs; red_c = mean_dia;
      end
      default: begin
        green_c = ctr;      blue_c = mean_hor;  red_c = mean_ver;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Two-entry output queue
  // --------------------------------------------------------------------------
  logic [RW-1:0] oq_r [2];
  logic          oq_wp_r, oq_rp_r;
  logic [1:0]    oq_cnt_r, oq_cnt_nxt;
  logic          push, pop;
  logic [RW-1:0] oq_head;

  assign push    = s1_valid_r && (s1_ctrl_r.emit_edge || s1_ctrl_r.emit_body);
  assign pop     = out_px.valid && out_px.ready;
  assign oq_head = oq_r[oq_rp_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    case ({push, pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 2'd1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 2'd1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (push) oq_wp_r <= ~oq_wp_r;
      if (pop)  oq_rp_r <= ~oq_rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_r[oq_wp_r] <= {red_c, green_c, blue_c, s1_ctrl_r.last};
    end
  end

  // Accept only while the queue has room for the item still in the window
  assign in_px.ready = ({1'b0, oq_cnt_r} + {2'b00, s1_valid_r}) <= (3'd1 + {2'b00, pop});

  assign out_px.valid      = (oq_cnt_r != 2'd0);
  assign out_px.red        = oq_head[RW-1:2*PIXEL_BITS+1];
  assign out_px.green      = oq_head[2*PIXEL_BITS:PIXEL_BITS+1];
  assign out_px.blue       = oq_head[PIXEL_BITS:1];
  assign out_px.last_pixel = oq_head[0];

endmodule

`default_nettype wire

// File: hw/rtl/dmsc_checker.sv
// ----------------------------------------------------------------------------
// Demosaic core port checker
// Watches the stream ports of the core for flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsc_checker #(
  parameter int PIXEL_BITS = dmsc_pkg::DEF_PIXEL_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_BITS-1:0] out_red,
  input logic [PIXEL_BITS-1:0] out_green,
  input logic [PIXEL_BITS-1:0] out_blue,
  input logic                  out_last
);

  // A held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
    $stable(out_green) && $stable(out_blue) && $stable(out_last))
    else $error("result changed while stalled");

  // With nothing waiting at the output the input must be open
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input closed with empty output");

  // A result only shows up after an item was taken and passed the window stage
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding item");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind bilinear_bayer_demosaic_core dmsc_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_dmsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_px.valid),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .out_red   (out_px.red),
  .out_green (out_px.green),
  .out_blue  (out_px.blue),
  .out_last  (out_px.last_pixel)
);

`default_nettype wire
